[design/mbmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked box mean filter package
// Shared constants, register indexes and reset values of the filter block.
// ----------------------------------------------------------------------------
package mbmf_pkg;

    // Default frame and window limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_RADIUS = 7;

    // Fixed field widths
    localparam int PIX_W        = 8;
    localparam int OUT_POS_W    = 11;
    localparam int DIM_W        = 12;
    localparam int RADIUS_W     = 3;
    localparam int MIN_COUNT_W  = 8;
    localparam int MASK_LIMIT_W = 9;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 12;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_LIMIT    = 3'd4;

    // Reset values
    localparam logic [DIM_W-1:0]        RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [DIM_W-1:0]        RST_IMAGE_HEIGHT  = 12'd480;
    localparam logic [RADIUS_W-1:0]     RST_WINDOW_RADIUS = 3'd1;
    localparam logic [MIN_COUNT_W-1:0]  RST_MIN_COUNT     = 8'd0;
    localparam logic [MASK_LIMIT_W-1:0] RST_MASK_LIMIT    = 9'd253;

    // Item kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Output value when too few pixels are valid
    localparam logic [PIX_W-1:0] PIX_SATURATED = 8'd255;

endpackage

[design/mbmf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/mbmf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out queue of window jobs between front and back.
// ----------------------------------------------------------------------------
module mbmf_queue import mbmf_pkg::*; #(
    parameter type job_t = logic
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job = entry_reg[rd_ptr_reg];
    assign full     = (32'(count_reg) == QUEUE_DEPTH);
    assign empty    = (count_reg == '0);

endmodule

[design/mbmf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filter front end
// Accepts items, writes pixels into the line memory, tracks input and output
// positions and issues one window job for each output that became ready.
// ----------------------------------------------------------------------------
module mbmf_front import mbmf_pkg::*; #(
    parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int  MAX_RADIUS = DEF_MAX_RADIUS,
    parameter type job_t      = logic,
    parameter type stat_t     = logic
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]           eff_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]          eff_height,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]          eff_radius,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic                                     s_mode,
    input  logic [PIX_W-1:0]                         s_pixel_value,
    input  logic                                     q_full,
    input  logic                                     q_empty,
    input  job_t                                     q_head,
    input  stat_t                                    rd_stat,
    output logic                                     push,
    output job_t                                     push_job,
    output logic                                     mem_we,
    output logic [$clog2((2*MAX_RADIUS+2)*(2**$clog2(MAX_WIDTH)))-1:0] mem_waddr,
    output logic [PIX_W-1:0]                         mem_wdata
);

    localparam int ROWS_KEPT = 2 * MAX_RADIUS + 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int RING_W    = $clog2(ROWS_KEPT);
    localparam int SPAN_W    = $clog2(2 * MAX_RADIUS + 1);
    localparam int ADDR_W    = $clog2(ROWS_KEPT * (2 ** COL_W));

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [RING_W-1:0] in_ring_reg, in_ring_next;
    logic [COL_W-1:0]  emit_col_reg, emit_col_next;
    logic [ROW_W-1:0]  emit_row_reg, emit_row_next;
    logic [RING_W-1:0] emit_ring_reg, emit_ring_next;
    logic              par_reg, par_next;

    logic              has_room;
    logic              pend_valid;
    logic              pend_par;
    logic [ROW_W-1:0]  pend_lo;
    logic              hazard;
    logic              accept;
    logic              store;
    logic [COL_W-1:0]  adv_col;
    logic [ROW_W-1:0]  adv_row;
    logic [RING_W-1:0] adv_ring;
    logic [ROW_W-1:0]  ry;
    logic [COL_W-1:0]  rx;
    logic              out_due;
    logic              frame_end;

    // Oldest job whose window reads are still to come
    always_comb begin
        pend_valid = 1'b0;
        pend_par   = 1'b0;
        pend_lo    = '0;
        if (rd_stat.busy) begin
            pend_valid = 1'b1;
            pend_par   = rd_stat.par;
            pend_lo    = rd_stat.row_lo;
        end else if (!q_empty) begin
            pend_valid = 1'b1;
            pend_par   = q_head.par;
            pend_lo    = q_head.row_lo;
        end
    end

    // A pixel write must not land on a row that a pending job still reads.
    assign has_room = (in_row_reg < eff_height);
    assign hazard   = pend_valid && has_room &&
                      ((pend_par != par_reg) ||
                       (32'(in_row_reg) >= 32'(pend_lo) + ROWS_KEPT));
    assign s_ready  = !q_full && !hazard;
    assign accept   = s_valid && s_ready;
    assign store    = accept && (s_mode == MODE_PIXEL) && has_room;

    // Line memory write
    assign mem_we    = store;
    assign mem_waddr = ADDR_W'({in_ring_reg, in_col_reg});
    assign mem_wdata = s_pixel_value;

    // Input position after this item
    always_comb begin
        adv_col  = in_col_reg;
        adv_row  = in_row_reg;
        adv_ring = in_ring_reg;
        if (store) begin
            if (32'(in_col_reg) + 1 >= 32'(eff_width)) begin
                adv_col  = '0;
                adv_row  = in_row_reg + 1'b1;
                adv_ring = (32'(in_ring_reg) == ROWS_KEPT - 1) ? '0 : in_ring_reg + 1'b1;
            end else begin
                adv_col = in_col_reg + 1'b1;
            end
        end
    end

    // Last input pixel that the next output's clipped window needs
    always_comb begin
        if (32'(emit_row_reg) + 32'(eff_radius) < 32'(eff_height) - 1) begin
            ry = ROW_W'(32'(emit_row_reg) + 32'(eff_radius));
        end else begin
            ry = ROW_W'(32'(eff_height) - 1);
        end
        if (32'(emit_col_reg) + 32'(eff_radius) < 32'(eff_width) - 1) begin
            rx = COL_W'(32'(emit_col_reg) + 32'(eff_radius));
        end else begin
            rx = COL_W'(32'(eff_width) - 1);
        end
    end

    assign out_due = (emit_row_reg < eff_height) &&
                     (32'(emit_col_reg) < 32'(eff_width)) &&
                     ((adv_row > ry) || ((adv_row == ry) && (adv_col > rx)));
    assign push    = accept && out_due;
    assign frame_end = (32'(emit_col_reg) + 1 >= 32'(eff_width)) &&
                       (32'(emit_row_reg) + 1 >= 32'(eff_height));

    // Window job description
    always_comb begin
        push_job        = '0;
        push_job.col    = emit_col_reg;
        push_job.row    = emit_row_reg;
        push_job.last   = frame_end;
        push_job.par    = par_reg;
        push_job.col_hi = rx;
        if (32'(emit_row_reg) >= 32'(eff_radius)) begin
            push_job.row_lo = ROW_W'(32'(emit_row_reg) - 32'(eff_radius));
            if (32'(emit_ring_reg) >= 32'(eff_radius)) begin
                push_job.ring_lo = RING_W'(32'(emit_ring_reg) - 32'(eff_radius));
            end else begin
                push_job.ring_lo = RING_W'(32'(emit_ring_reg) + ROWS_KEPT -
                                           32'(eff_radius));
            end
        end else begin
            push_job.row_lo  = '0;
            push_job.ring_lo = '0;
        end
        push_job.rows_m1 = SPAN_W'(32'(ry) - 32'(push_job.row_lo));
        if (32'(emit_col_reg) >= 32'(eff_radius)) begin
            push_job.col_lo = COL_W'(32'(emit_col_reg) - 32'(eff_radius));
        end else begin
            push_job.col_lo = '0;
        end
    end

    // Position counters
    always_comb begin
        in_col_next    = adv_col;
        in_row_next    = adv_row;
        in_ring_next   = adv_ring;
        emit_col_next  = emit_col_reg;
        emit_row_next  = emit_row_reg;
        emit_ring_next = emit_ring_reg;
        par_next       = par_reg;
        if (restart) begin
            in_col_next    = '0;
            in_row_next    = '0;
            in_ring_next   = '0;
            emit_col_next  = '0;
            emit_row_next  = '0;
            emit_ring_next = '0;
        end else if (push) begin
            if (frame_end) begin
                in_col_next    = '0;
                in_row_next    = '0;
                in_ring_next   = '0;
                emit_col_next  = '0;
                emit_row_next  = '0;
                emit_ring_next = '0;
                par_next       = !par_reg;
            end else if (32'(emit_col_reg) + 1 >= 32'(eff_width)) begin
                emit_col_next  = '0;
                emit_row_next  = emit_row_reg + 1'b1;
                emit_ring_next = (32'(emit_ring_reg) == ROWS_KEPT - 1) ? '0 :
                                 emit_ring_reg + 1'b1;
            end else begin
                emit_col_next = emit_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_ring_reg   <= '0;
            emit_col_reg  <= '0;
            emit_row_reg  <= '0;
            emit_ring_reg <= '0;
            par_reg       <= 1'b0;
        end else begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_ring_reg   <= in_ring_next;
            emit_col_reg  <= emit_col_next;
            emit_row_reg  <= emit_row_next;
            emit_ring_reg <= emit_ring_next;
            par_reg       <= par_next;
        end
    end

endmodule

[design/mbmf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filter back end
// Walks each job's window through the line memory, counts and sums the valid
// pixels, divides bit by bit and holds the result in the output register.
// ----------------------------------------------------------------------------
module mbmf_back import mbmf_pkg::*; #(
    parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int  MAX_RADIUS = DEF_MAX_RADIUS,
    parameter type job_t      = logic,
    parameter type stat_t     = logic
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [MIN_COUNT_W-1:0]     min_count,
    input  logic [MASK_LIMIT_W-1:0]    mask_limit,
    input  logic                       q_empty,
    input  job_t                       q_head,
    output logic                       pop,
    output stat_t                      rd_stat,
    output logic [$clog2((2*MAX_RADIUS+2)*(2**$clog2(MAX_WIDTH)))-1:0] mem_raddr,
    input  logic [PIX_W-1:0]           mem_rdata,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [PIX_W-1:0]           m_filtered_value,
    output logic [OUT_POS_W-1:0]       m_out_col,
    output logic [OUT_POS_W-1:0]       m_out_row,
    output logic                       m_last_of_frame
);

    localparam int ROWS_KEPT = 2 * MAX_RADIUS + 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int RING_W    = $clog2(ROWS_KEPT);
    localparam int SPAN_W    = $clog2(2 * MAX_RADIUS + 1);
    localparam int ADDR_W    = $clog2(ROWS_KEPT * (2 ** COL_W));
    localparam int WIN_MAX   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W     = $clog2(WIN_MAX + 1);
    localparam int SUM_W     = $clog2(WIN_MAX * 255 + 1);
    localparam int STEP_W    = $clog2(SUM_W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    job_t              job_reg;
    logic [RING_W-1:0] ring_reg;
    logic [SPAN_W-1:0] rows_left_reg;
    logic [COL_W-1:0]  xc_reg;
    logic              rd_pend_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_valid_reg;
    logic [PIX_W-1:0]  value_reg;
    logic [OUT_POS_W-1:0] col_reg;
    logic [OUT_POS_W-1:0] row_reg;
    logic              last_reg;

    logic              load_out;
    logic [CNT_W:0]    trial;
    logic              qbit;
    logic              pix_ok;
    logic [PIX_W-1:0]  result;

    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign mem_raddr = ADDR_W'({ring_reg, xc_reg});

    // Read status seen by the front end's write guard
    always_comb begin
        rd_stat        = '0;
        rd_stat.busy   = (state_reg == ST_READ);
        rd_stat.par    = job_reg.par;
        rd_stat.row_lo = job_reg.row_lo;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if ((xc_reg == job_reg.col_hi) && (rows_left_reg == '0)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (32'(step_reg) == SUM_W - 1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_READ);
        end
    end

    // Restoring division step: one quotient bit per cycle
    assign trial  = {rem_reg, sum_reg[SUM_W-1]};
    assign qbit   = (trial >= {1'b0, cnt_reg});
    assign pix_ok = ({1'b0, mem_rdata} < mask_limit);

    // Window walk, accumulation and division datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    job_reg       <= q_head;
                    ring_reg      <= q_head.ring_lo;
                    rows_left_reg <= q_head.rows_m1;
                    xc_reg        <= q_head.col_lo;
                    sum_reg       <= '0;
                    cnt_reg       <= '0;
                    rem_reg       <= '0;
                    step_reg      <= '0;
                end
            end
            ST_READ: begin
                if (xc_reg == job_reg.col_hi) begin
                    xc_reg <= job_reg.col_lo;
                    if (rows_left_reg != '0) begin
                        rows_left_reg <= rows_left_reg - 1'b1;
                        ring_reg <= (32'(ring_reg) == ROWS_KEPT - 1) ? '0 :
                                    ring_reg + 1'b1;
                    end
                end else begin
                    xc_reg <= xc_reg + 1'b1;
                end
            end
            ST_DIV: begin
                if (qbit) begin
                    rem_reg <= CNT_W'(trial - {1'b0, cnt_reg});
                end else begin
                    rem_reg <= CNT_W'(trial);
                end
                sum_reg  <= {sum_reg[SUM_W-2:0], qbit};
                step_reg <= step_reg + 1'b1;
            end
            default: begin
            end
        endcase
        // Data of the read issued in the cycle before
        if (rd_pend_reg && pix_ok) begin
            sum_reg <= sum_reg + SUM_W'(mem_rdata);
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Final value: saturate when too few valid pixels
    assign result = ((cnt_reg == '0) || (32'(cnt_reg) <= 32'(min_count))) ?
                    PIX_SATURATED : sum_reg[PIX_W-1:0];

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            value_reg <= result;
            col_reg   <= OUT_POS_W'(job_reg.col);
            row_reg   <= OUT_POS_W'(job_reg.row);
            last_reg  <= job_reg.last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_value = value_reg;
    assign m_out_col        = col_reg;
    assign m_out_row        = row_reg;
    assign m_last_of_frame  = last_reg;

    // Division must finish within the dividend width.
    a_div_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (32'(step_reg) < SUM_W))
        else $error("division ran past the dividend width");

    // No read is outstanding once the division starts.
    a_div_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !rd_pend_reg)
        else $error("window read still pending during division");

    // A result is loaded only when the output register is free or drains.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

endmodule

[design/masked_box_mean_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked box mean filter
// Averages the pixels below the mask limit in a square window around each
// pixel of a raster-order grayscale frame.
// ----------------------------------------------------------------------------
// The front end takes one item per clock as long as the two-entry job queue
// has room and the pixel would not overwrite a line-memory row that a queued
// job still has to read. Each result is computed by the back end, which reads
// the clipped window through the single read port of the line memory, one
// pixel per clock, and then divides bit-serially. Pixels and flush items that
// cause no output pass at one per clock under the same conditions. A write to
// any register restarts the frame.
// ----------------------------------------------------------------------------
module masked_box_mean_filter_top import mbmf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [PIX_W-1:0]      s_pixel_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_filtered_value,
    output logic [OUT_POS_W-1:0]  m_out_col,
    output logic [OUT_POS_W-1:0]  m_out_row,
    output logic                  m_last_of_frame
);

    localparam int ROWS_KEPT = 2 * MAX_RADIUS + 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
    localparam int RING_W    = $clog2(ROWS_KEPT);
    localparam int SPAN_W    = $clog2(2 * MAX_RADIUS + 1);
    localparam int MEM_DEPTH = ROWS_KEPT * (2 ** COL_W);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              last;
        logic              par;
        logic [ROW_W-1:0]  row_lo;
        logic [RING_W-1:0] ring_lo;
        logic [SPAN_W-1:0] rows_m1;
        logic [COL_W-1:0]  col_lo;
        logic [COL_W-1:0]  col_hi;
    } mbmf_job_t;

    typedef struct packed {
        logic             busy;
        logic             par;
        logic [ROW_W-1:0] row_lo;
    } mbmf_stat_t;

    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic [RADIUS_W-1:0]     radius_reg;
    logic [MIN_COUNT_W-1:0]  min_count_reg;
    logic [MASK_LIMIT_W-1:0] mask_limit_reg;
    logic                    cfg_write;
    logic                    restart;

    logic [WID_W-1:0] eff_width;
    logic [ROW_W-1:0] eff_height;
    logic [RAD_W-1:0] eff_radius;

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    mbmf_job_t         push_job;
    mbmf_job_t         q_head;
    mbmf_stat_t        rd_stat;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [PIX_W-1:0]  mem_wdata;
    logic [PIX_W-1:0]  mem_rdata;

    // Configuration registers; a write to a known index restarts the frame.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        case (cfg_index)
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_WINDOW_RADIUS,
            REG_MIN_COUNT, REG_MASK_LIMIT: begin
                restart = cfg_write;
            end
            default: begin
                restart = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= RST_IMAGE_WIDTH;
            height_reg     <= RST_IMAGE_HEIGHT;
            radius_reg     <= RST_WINDOW_RADIUS;
            min_count_reg  <= RST_MIN_COUNT;
            mask_limit_reg <= RST_MASK_LIMIT;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_data;
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_data;
                end
                REG_WINDOW_RADIUS: begin
                    radius_reg <= cfg_data[RADIUS_W-1:0];
                end
                REG_MIN_COUNT: begin
                    min_count_reg <= cfg_data[MIN_COUNT_W-1:0];
                end
                REG_MASK_LIMIT: begin
                    mask_limit_reg <= cfg_data[MASK_LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Frame size and radius clamped to the supported range
    always_comb begin
        if (width_reg == '0) begin
            eff_width = WID_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            eff_width = WID_W'(MAX_WIDTH);
        end else begin
            eff_width = WID_W'(width_reg);
        end
        if (height_reg == '0) begin
            eff_height = ROW_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            eff_height = ROW_W'(MAX_HEIGHT);
        end else begin
            eff_height = ROW_W'(height_reg);
        end
        if (32'(radius_reg) > MAX_RADIUS) begin
            eff_radius = RAD_W'(MAX_RADIUS);
        end else begin
            eff_radius = RAD_W'(radius_reg);
        end
    end

    mbmf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS),
        .job_t      (mbmf_job_t),
        .stat_t     (mbmf_stat_t)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .restart       (restart),
        .eff_width     (eff_width),
        .eff_height    (eff_height),
        .eff_radius    (eff_radius),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_pixel_value (s_pixel_value),
        .q_full        (q_full),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .rd_stat       (rd_stat),
        .push          (push),
        .push_job      (push_job),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata)
    );

    mbmf_queue #(
        .job_t (mbmf_job_t)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Ring of the most recent input rows
    mbmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MEM_DEPTH)
    ) u_line_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mbmf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .job_t      (mbmf_job_t),
        .stat_t     (mbmf_stat_t)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .min_count        (min_count_reg),
        .mask_limit       (mask_limit_reg),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .pop              (pop),
        .rd_stat          (rd_stat),
        .mem_raddr        (mem_raddr),
        .mem_rdata        (mem_rdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_out_col        (m_out_col),
        .m_out_row        (m_out_row),
        .m_last_of_frame  (m_last_of_frame)
    );

    // The queue never takes a job while full.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("job pushed into a full queue");

    // The back end only takes a job that exists.
    a_pop_avail: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("job taken from an empty queue");

    // A new job is not taken while the previous window is still read.
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !rd_stat.busy)
        else $error("job taken during a window read");

endmodule
